// File: src/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

  localparam int NUM_SETS          = 64;
  localparam int NUM_WAYS          = 4;
  localparam int BLOCK_OFFSET_BITS = 6;
  localparam int ADDRESS_BITS      = 32;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AGE_W  = WAY_W;
  localparam int TAG_W  = ADDRESS_BITS - BLOCK_OFFSET_BITS - SET_W;
  localparam int FIELD_W = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [SET_W-1:0] set_idx_t;
  typedef logic [WAY_W-1:0] way_idx_t;
  typedef logic [AGE_W-1:0] age_t;

  // one RAM row holds the whole state of a set except the valid bits
  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
    logic [NUM_WAYS-1:0]            dirty;
    logic [NUM_WAYS-1:0][AGE_W-1:0] age;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  typedef struct packed {
    logic     hit;
    way_idx_t way;
    logic     writeback;
    tag_t     victim_tag;
  } lookup_t;

  function automatic logic [FIELD_W-1:0] block_addr(tag_t tag, set_idx_t set_idx);
    logic [ADDRESS_BITS-1:0] a;
    a = {tag, set_idx, {BLOCK_OFFSET_BITS{1'b0}}};
    return FIELD_W'(a);
  endfunction

endpackage

`default_nettype wire

// File: src/sacl_ram.sv
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/sacl_lookup.sv
`default_nettype none

module sacl_lookup (
  input  wire logic                              store,
  input  wire sacl_pkg::tag_t                    tag,
  input  wire logic [sacl_pkg::NUM_WAYS-1:0]     set_valid,
  input  wire sacl_pkg::set_row_t                row,
  output sacl_pkg::lookup_t                      res,
  output sacl_pkg::set_row_t                     row_next,
  output logic      [sacl_pkg::NUM_WAYS-1:0]     set_valid_next
);

  import sacl_pkg::*;

  logic     hit;
  logic     any_inv;
  way_idx_t hit_way;
  way_idx_t inv_way;
  way_idx_t lru_way;
  age_t     lru_age;
  way_idx_t way;
  logic [AGE_W:0] old_age;

  always_comb begin
    hit     = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    lru_age = row.age[0];
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!hit && set_valid[i] && row.tag[i] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!any_inv && !set_valid[i]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(i);
      end
      if (i != 0 && row.age[i] > lru_age) begin
        lru_age = row.age[i];
        lru_way = WAY_W'(i);
      end
    end

    priority if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end

    res.hit        = hit;
    res.way        = way;
    res.writeback  = !hit && !any_inv && row.dirty[way];
    res.victim_tag = row.tag[way];

    // an invalid way counts as older than every valid one
    old_age = set_valid[way] ? {1'b0, row.age[way]} : (AGE_W+1)'(NUM_WAYS);

    row_next       = row;
    set_valid_next = set_valid;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (WAY_W'(i) == way) begin
        row_next.age[i] = '0;
      end else if (set_valid[i] && {1'b0, row.age[i]} < old_age) begin
        row_next.age[i] = row.age[i] + 1'b1;
      end
    end
    set_valid_next[way] = 1'b1;
    if (hit) begin
      row_next.dirty[way] = row.dirty[way] | store;
    end else begin
      row_next.tag[way]   = tag;
      row_next.dirty[way] = store;
    end
  end

endmodule

`default_nettype wire

// File: src/set_assoc_cache_lru_controller.sv
`default_nettype none

// Tag/valid/dirty/LRU controller of a 4-way, 64-set write-back write-allocate
// cache with 64-byte blocks. One access (s_tuser: 0 load, 1 store; s_tdata:
// byte address) is taken per cycle unless m_tready back-pressure stalls it; its
// result word passes from the s1 registers to the m_tdata output register once
// that register is free. The per-set tags, dirty bits and LRU ages live in one RAM
// row read as the access is accepted and written back as it commits; the
// last written row is bypassed to the next access of the same set, so
// back-to-back accesses need no stall. Valid bits sit in flip-flops cleared
// by reset, so the block is usable right after reset. Victim and fill block
// addresses are zero when no writeback or no fill is needed. The four
// statistics counters wrap and are reported after counting the access.
module set_assoc_cache_lru_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,  // address
  input  wire logic [0:0]   s_tuser,  // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [199:0] m_tdata   // hit, way[1:0], writeback, victim_block_address,
                                      // fill_block_address, read_queries, read_misses,
                                      // write_queries, write_misses, 4'b0 pad
);

  import sacl_pkg::*;

  localparam int FIELD_ADDR_W = 32;

  logic [ADDRESS_BITS-1:0] in_addr;
  set_idx_t                in_set;
  logic                    accept;
  logic                    commit;

  logic     s1_valid;
  logic     s1_store;
  tag_t     s1_tag;
  set_idx_t s1_set;

  logic     fwd_valid;
  set_idx_t fwd_set;
  set_row_t fwd_row;

  logic [ROW_W-1:0]          ram_rdata;
  set_row_t                  cur_row;
  logic [NUM_WAYS-1:0]       cur_valid;
  lookup_t                   res;
  set_row_t                  row_next;
  logic [NUM_WAYS-1:0]       valid_next;
  logic [NUM_SETS-1:0][NUM_WAYS-1:0] line_valid;

  logic [31:0] read_queries;
  logic [31:0] read_misses;
  logic [31:0] write_queries;
  logic [31:0] write_misses;
  logic [31:0] read_queries_next;
  logic [31:0] read_misses_next;
  logic [31:0] write_queries_next;
  logic [31:0] write_misses_next;

  assign in_addr  = ADDRESS_BITS'(s_tdata[FIELD_ADDR_W-1:0]);
  assign in_set   = in_addr[BLOCK_OFFSET_BITS +: SET_W];
  assign commit   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || commit;
  assign accept   = s_tvalid && s_tready;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (s1_set),
    .wdata (row_next),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  assign cur_row   = (fwd_valid && fwd_set == s1_set) ? fwd_row : set_row_t'(ram_rdata);
  assign cur_valid = line_valid[s1_set];

  sacl_lookup u_lookup (
    .store          (s1_store),
    .tag            (s1_tag),
    .set_valid      (cur_valid),
    .row            (cur_row),
    .res            (res),
    .row_next       (row_next),
    .set_valid_next (valid_next)
  );

  always_comb begin
    read_queries_next  = read_queries;
    read_misses_next   = read_misses;
    write_queries_next = write_queries;
    write_misses_next  = write_misses;
    if (s1_store == CMD_STORE) begin
      write_queries_next = write_queries + 32'd1;
      if (!res.hit) begin
        write_misses_next = write_misses + 32'd1;
      end
    end else begin
      read_queries_next = read_queries + 32'd1;
      if (!res.hit) begin
        read_misses_next = read_misses + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
      line_valid    <= '0;
      read_queries  <= '0;
      read_misses   <= '0;
      write_queries <= '0;
      write_misses  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        m_tvalid             <= 1'b1;
        fwd_valid            <= 1'b1;
        line_valid[s1_set]   <= valid_next;
        read_queries         <= read_queries_next;
        read_misses          <= read_misses_next;
        write_queries        <= write_queries_next;
        write_misses         <= write_misses_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_store <= s_tuser[0];
      s1_tag   <= in_addr[ADDRESS_BITS-1 -: TAG_W];
      s1_set   <= in_set;
    end
    if (commit) begin
      fwd_set <= s1_set;
      fwd_row <= row_next;
      m_tdata <= {4'b0,
                  write_misses_next, write_queries_next,
                  read_misses_next, read_queries_next,
                  res.hit ? 32'd0 : block_addr(s1_tag, s1_set),
                  res.writeback ? block_addr(res.victim_tag, s1_set) : 32'd0,
                  res.writeback,
                  2'(res.way),
                  res.hit};
    end
  end

endmodule

`default_nettype wire
